FILE: src/tlp_pkg.sv
// Shared types and constants for the throttle load predictor.
package tlp_pkg;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  throttle;
    logic [15:0] time_now;
    logic [15:0] basic_load;
    logic [15:0] next_tdc_time;
    logic [15:0] load_in;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        load_out;
    logic signed [15:0] load_delta;
    logic               applied;
  } out_word_t;

  // operands of the serial multiply-then-divide unit
  typedef struct packed {
    logic [15:0] mcand;
    logic [15:0] mplier;
    logic [15:0] divisor;
  } md_req_t;

  localparam logic CMD_SAVE    = 1'b0;
  localparam logic CMD_PREDICT = 1'b1;

  localparam logic REG_LOAD_CEILING = 1'b0;

  localparam logic [15:0]        CEILING_RESET = 16'hFFFF;
  localparam logic [15:0]        LOAD_FLOOR    = 16'd5;
  localparam logic signed [8:0]  TPS_STEP      = 9'sd5;
  localparam logic signed [15:0] QTR_BIAS      = 16'sd3;

  localparam logic [4:0] MUL_LAST = 5'd15;
  localparam logic [4:0] DIV_LAST = 5'd31;

endpackage

FILE: src/tlp_muldiv.sv
// Bit-serial unsigned 16x16 multiply followed by restoring 32/16 divide.
module tlp_muldiv import tlp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  md_req_t     req,
  output logic        done,
  output logic [15:0] quot
);

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_t;

  md_state_t   state_r;
  logic [4:0]  cnt_r;
  logic [31:0] prod_r;
  logic [15:0] rem_r;
  logic [15:0] mcand_r;
  logic [15:0] div_r;
  logic        done_r;

  logic [16:0] mul_sum;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  assign mul_sum = {1'b0, prod_r[31:16]} + (prod_r[0] ? {1'b0, mcand_r} : 17'd0);
  assign trial   = {rem_r, prod_r[31]};
  assign diff    = trial - {1'b0, div_r};
  assign ge      = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        MD_IDLE: begin
          if (start) begin
            prod_r  <= {16'd0, req.mplier};
            mcand_r <= req.mcand;
            div_r   <= req.divisor;
            cnt_r   <= '0;
            state_r <= MD_MUL;
          end
        end
        MD_MUL: begin
          prod_r <= {mul_sum, prod_r[15:1]};
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == MUL_LAST) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            state_r <= MD_DIV;
          end
        end
        MD_DIV: begin
          prod_r <= {prod_r[30:0], ge};
          rem_r  <= ge ? diff[15:0] : trial[15:0];
          cnt_r  <= cnt_r + 5'd1;
          if (cnt_r == DIV_LAST) begin
            done_r  <= 1'b1;
            state_r <= MD_IDLE;
          end
        end
        default: state_r <= MD_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign quot = prod_r[15:0];

endmodule

FILE: src/throttle_load_predictor_unit.sv
// Throttle load predictor: top level with control sequencer and registers.
//
// Input words arrive on in_valid/in_stall/in_data; one result word per input
// word leaves on out_valid/out_stall/out_data. A word is taken at a clock edge
// with valid high and stall low.
// A save word (cmd 0) records throttle, timer and basic load and returns
// load_in unchanged; it passes S_PREP and S_DONE on to the output register.
// A predict word that applies a correction runs a bit-serial multiply and a
// restoring divide in tlp_muldiv, plus setup, start, sign, quartering,
// clamping and output load on the way to the output register. One word is
// processed at a time and in_stall is high while a word is in work, so the
// next word is taken only once the current one is in the output register.
// The output register holds a finished word while out_stall is high; the
// next input word is taken meanwhile, and its result waits until the output
// register is free.
// load_ceiling sits at byte address 0 of the APB port; reset sets it to 65535
// and clears the saved sample and all handshake state.
module throttle_load_predictor_unit import tlp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_CALC, S_QTR, S_SUM, S_DONE} state_t;

  state_t             state_r;
  logic [15:0]        ceiling_r;
  logic [7:0]         saved_thr_r;
  logic [15:0]        saved_time_r;
  logic [15:0]        saved_load_r;
  logic signed [8:0]  dtps_r;
  logic [15:0]        dt1_r;
  logic [15:0]        dt2_r;
  logic signed [15:0] dld_r;
  logic [15:0]        load_r;
  logic               cmd_r;
  logic               neg_r;
  logic               fell_r;
  logic signed [15:0] delta_r;
  out_word_t          res_r;
  out_word_t          out_data_r;
  logic               out_valid_r;
  logic               md_start_r;
  md_req_t            md_req_r;

  logic               in_acc;
  logic               cfg_wr;
  logic               moved;
  logic [18:0]        dt1_x5;
  logic [15:0]        dt2_lim;
  logic [15:0]        dld_mag;
  logic               md_done;
  logic [15:0]        md_quot;
  logic signed [15:0] qtr_sum;
  logic [15:0]        sum;
  logic [15:0]        capped;
  logic               out_free;

  tlp_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start_r),
    .req   (md_req_r),
    .done  (md_done),
    .quot  (md_quot)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign moved   = (dtps_r >= TPS_STEP) || (dtps_r <= -TPS_STEP);
  assign dt1_x5  = {3'b000, dt1_r} + {1'b0, dt1_r, 2'b00};
  assign dt2_lim = ({3'b000, dt2_r} >= dt1_x5) ? {dt1_r[13:0], 2'b00} : dt2_r;
  assign dld_mag = dld_r[15] ? (16'd0 - dld_r) : dld_r;

  assign qtr_sum = delta_r + (delta_r[15] ? QTR_BIAS : 16'sd0);
  assign sum     = load_r + delta_r;
  assign capped  = (sum > ceiling_r) ? ceiling_r : sum;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_LOAD_CEILING) ? {16'd0, ceiling_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_r <= CEILING_RESET;
    end else if (cfg_wr && (paddr[2] == REG_LOAD_CEILING)) begin
      ceiling_r <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      saved_thr_r  <= '0;
      saved_time_r <= '0;
      saved_load_r <= '0;
      out_valid_r  <= 1'b0;
      md_start_r   <= 1'b0;
    end else begin
      md_start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            dtps_r  <= $signed({1'b0, in_data.throttle}) - $signed({1'b0, saved_thr_r});
            dt1_r   <= in_data.time_now - saved_time_r;
            dt2_r   <= in_data.next_tdc_time - in_data.time_now;
            dld_r   <= in_data.basic_load - saved_load_r;
            load_r  <= in_data.load_in;
            cmd_r   <= in_data.cmd;
            state_r <= S_PREP;
            if (in_data.cmd == CMD_SAVE) begin
              saved_thr_r  <= in_data.throttle;
              saved_time_r <= in_data.time_now;
              saved_load_r <= in_data.basic_load;
            end
          end
        end
        S_PREP: begin
          if (cmd_r == CMD_PREDICT && moved && dt1_r != 16'd0) begin
            md_req_r   <= '{mcand: dt2_lim, mplier: dld_mag, divisor: dt1_r};
            md_start_r <= 1'b1;
            neg_r      <= dld_r[15];
            fell_r     <= dtps_r[8];
            state_r    <= S_CALC;
          end else begin
            res_r   <= '{load_out: load_r, load_delta: 16'sd0, applied: 1'b0};
            state_r <= S_DONE;
          end
        end
        S_CALC: begin
          if (md_done) begin
            delta_r <= neg_r ? (16'd0 - md_quot) : md_quot;
            state_r <= S_QTR;
          end
        end
        S_QTR: begin
          if (fell_r) begin
            delta_r <= qtr_sum >>> 2;
          end
          state_r <= S_SUM;
        end
        S_SUM: begin
          res_r   <= '{load_out: (capped < LOAD_FLOOR) ? LOAD_FLOOR : capped,
                       load_delta: delta_r, applied: 1'b1};
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/tlp_checker.sv
// Port-level assertions for the throttle load predictor, bound to the top level.
module tlp_checker import tlp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input out_word_t   out_data
);

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after acceptance");

  a_no_delta_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.applied |-> out_data.load_delta == 16'sd0)
    else $error("nonzero delta on a word without prediction");

  a_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.applied |-> out_data.load_out >= LOAD_FLOOR)
    else $error("predicted load below floor");

endmodule

bind throttle_load_predictor_unit tlp_checker u_tlp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
